[hw/rtl/assert_macros.svh]
// Assertion macros for the integer square root RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication or plain property, sampled on clk, off while rst_n is low.
`define ISQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be seen on a clock edge out of reset.
`define ISQ_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

[hw/rtl/isqrt_pkg.sv]
// Constants for the integer square root design.
package isqrt_pkg;

    // Width of the root result port.
    localparam int ROOT_W = 16;

endpackage

[hw/rtl/isqrt_cell.sv]
// One cell of the square root chain: decides a single root bit.
module isqrt_cell #(
    parameter int XW  = 32,
    parameter int RW  = 16,
    parameter int BIT = 0
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          vld_in,
    input  logic [XW-1:0] rem_in,
    input  logic [RW-1:0] root_in,
    output logic          vld_out,
    output logic [XW-1:0] rem_out,
    output logic [RW-1:0] root_out
);

    localparam logic [XW-1:0] SQ_BIT   = XW'(1) << (2 * BIT);
    localparam logic [RW-1:0] ROOT_BIT = RW'(1) << BIT;

    logic          vld_reg;
    logic [XW-1:0] rem_reg;
    logic [XW-1:0] rem_next;
    logic [RW-1:0] root_reg;
    logic [RW-1:0] root_next;
    logic [XW-1:0] trial;
    logic          take;

    // (r + 2^b)^2 - r^2 = r * 2^(b+1) + 2^(2b); r has no bits at or below b
    assign trial = (XW'(root_in) << (BIT + 1)) | SQ_BIT;
    assign take  = (rem_in >= trial);

    always_comb
    begin
        rem_next  = rem_in;
        root_next = root_in;
        if (take)
        begin
            rem_next  = rem_in - trial;
            root_next = root_in | ROOT_BIT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_in;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign vld_out  = vld_reg;
    assign rem_out  = rem_reg;
    assign root_out = root_reg;

endmodule

[hw/rtl/integer_square_root_top.sv]
// Top level of the pipelined integer square root.
//
//  channel   signals                  direction  accepted when
//  request   start, busy, radicand    in         start && !busy
//  result    done, root               out        done (one cycle, no stall)
//
// The chain has one registered cell per root bit; a new request may enter every cycle.
// Each cell holds one compare-and-subtract on the running remainder.
// Reset clears only the valid bits of the chain; busy is never raised.
// The receiver cannot stall: every result appears once, in request order.
`include "assert_macros.svh"

module integer_square_root_top #(
    parameter int INPUT_WIDTH = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [INPUT_WIDTH-1:0]         radicand,
    output logic                           done,
    output logic [isqrt_pkg::ROOT_W-1:0]   root
);

    localparam int RW = (INPUT_WIDTH + 1) / 2;
    localparam int XW = 2 * RW;

    logic          vld_chain  [0:RW];
    logic [XW-1:0] rem_chain  [0:RW];
    logic [RW-1:0] root_chain [0:RW];
    logic [isqrt_pkg::ROOT_W+RW-1:0] root_ext;

    assign vld_chain[0]  = start;
    assign rem_chain[0]  = XW'(radicand);
    assign root_chain[0] = '0;

    // cell k settles root bit RW-1-k, most significant first
    for (genvar k = 0; k < RW; k++)
    begin : g_cell
        isqrt_cell #(
            .XW  (XW),
            .RW  (RW),
            .BIT (RW - 1 - k)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .vld_in   (vld_chain[k]),
            .rem_in   (rem_chain[k]),
            .root_in  (root_chain[k]),
            .vld_out  (vld_chain[k+1]),
            .rem_out  (rem_chain[k+1]),
            .root_out (root_chain[k+1])
        );
    end

    assign root_ext = {{isqrt_pkg::ROOT_W{1'b0}}, root_chain[RW]};
    assign root     = root_ext[isqrt_pkg::ROOT_W-1:0];
    assign done     = vld_chain[RW];
    assign busy     = 1'b0;

    `ISQ_ASSERT(a_req_to_done, start |-> ##RW done, "request did not produce a result")
    `ISQ_ASSERT(a_done_has_req, done |-> $past(start, RW), "result without a request")
    `ISQ_NEVER(a_rem_bound, done && (rem_chain[RW] > {root_chain[RW], 1'b0}), "root too small")

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// Testbench for integer_square_root_top: directed and random radicands against a predictor.
module tb_top;

    localparam int RAD_W      = 32;
    localparam int RANDOM_N   = 1000;
    localparam int DIRECTED_N = 24;
    localparam int DRAIN_CYC  = 40;

    typedef logic [RAD_W-1:0]  radicand_t;
    typedef logic [isqrt_pkg::ROOT_W-1:0] root_t;

    typedef struct packed {
        radicand_t value;
        logic      typed;
        root_t     root;
    } sqrt_row_t;

    // Rows with typed set carry a root readable at a glance; the others use the predictor.
    localparam sqrt_row_t SQRT_ROWS [DIRECTED_N] = '{
        '{32'h0000_0000, 1'b1, 16'd0},
        '{32'h0000_0001, 1'b1, 16'd1},
        '{32'h0000_0002, 1'b1, 16'd1},
        '{32'h0000_0003, 1'b1, 16'd1},
        '{32'h0000_0004, 1'b1, 16'd2},
        '{32'h0000_000F, 1'b1, 16'd3},
        '{32'h0000_0010, 1'b1, 16'd4},
        '{32'h0000_00FF, 1'b1, 16'd15},
        '{32'h0000_0100, 1'b1, 16'd16},
        '{32'h0000_1000, 1'b1, 16'd64},
        '{32'h0000_4000, 1'b1, 16'd128},
        '{32'h0000_8000, 1'b0, 16'd0},
        '{32'h0001_0000, 1'b1, 16'd256},
        '{32'h3FFF_FFFF, 1'b1, 16'd32767},
        '{32'h4000_0000, 1'b1, 16'd32768},
        '{32'h8000_0000, 1'b0, 16'd0},
        '{32'h5555_5555, 1'b0, 16'd0},
        '{32'hAAAA_AAAA, 1'b0, 16'd0},
        '{32'hFFFE_0000, 1'b1, 16'd65534},
        '{32'hFFFE_0001, 1'b1, 16'd65535},
        '{32'hFFFE_0002, 1'b1, 16'd65535},
        '{32'hFFFF_FFFE, 1'b1, 16'd65535},
        '{32'hFFFF_FFFF, 1'b1, 16'd65535},
        '{32'h0001_FFFF, 1'b0, 16'd0}
    };

    logic      clk;
    logic      rst_n;
    logic      start;
    logic      busy;
    radicand_t radicand;
    logic      done;
    root_t     root;

    // Side channel that travels with each request: typed expectation, if any.
    logic      req_typed;
    root_t     req_root;

    root_t     root_q[$];
    int        mismatch_count;

    integer_square_root_top #(
        .INPUT_WIDTH(RAD_W)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .radicand(radicand),
        .done    (done),
        .root    (root)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Binary search on the root bits: keep a bit if its square still fits.
    function automatic root_t floor_root(radicand_t x);
        longint unsigned guess;
        longint unsigned trial;
        guess = 0;
        for (int b = isqrt_pkg::ROOT_W - 1; b >= 0; b--)
        begin
            trial = guess | (64'd1 << b);
            if (trial * trial <= {32'd0, x})
                guess = trial;
        end
        return root_t'(guess);
    endfunction

    function automatic radicand_t pick_radicand();
        radicand_t k;
        k = radicand_t'($urandom_range(0, 65535));
        case ($urandom_range(0, 5))
            0:       return radicand_t'(k * k);
            1:       return radicand_t'(k * k) - radicand_t'(1);
            2:       return radicand_t'(k * k) + radicand_t'($urandom_range(1, 2 * 65535));
            3:       return radicand_t'($urandom_range(0, 1023));
            4:       return radicand_t'(~32'd0) - radicand_t'($urandom_range(0, 1 << 18));
            default: return radicand_t'($urandom);
        endcase
    endfunction

    // Record the expectation on each accepted request and check each result.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                root_q.push_back(req_typed ? req_root : floor_root(radicand));
            if (done)
            begin
                if (root_q.size() == 0)
                begin
                    $display("%0t: unexpected root, expected none, actual %0d", $time, root);
                    mismatch_count++;
                end
                else
                begin
                    root_t want;
                    want = root_q.pop_front();
                    if (root !== want)
                    begin
                        $display("%0t: root mismatch, expected %0d, actual %0d",
                                 $time, want, root);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    int burst_left;

    // Drive one request; gaps land only between bursts.
    task automatic send_request(radicand_t value, logic typed, root_t want);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 20);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        start     <= 1'b1;
        radicand  <= value;
        req_typed <= typed;
        req_root  <= want;
        do
            @(posedge clk);
        while (busy);
    endtask

    initial
    begin
        int wait_cyc;
        start          = 1'b0;
        radicand       = '0;
        req_typed      = 1'b0;
        req_root       = '0;
        rst_n          = 1'b0;
        mismatch_count = 0;
        burst_left     = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (SQRT_ROWS[i])
            send_request(SQRT_ROWS[i].value, SQRT_ROWS[i].typed, SQRT_ROWS[i].root);

        for (int n = 0; n < RANDOM_N; n++)
            send_request(pick_radicand(), 1'b0, '0);

        start <= 1'b0;
        wait_cyc = 0;
        while (root_q.size() != 0 && wait_cyc < 1000)
        begin
            @(posedge clk);
            wait_cyc++;
        end
        repeat (DRAIN_CYC) @(posedge clk);

        if (mismatch_count == 0 && root_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

[integer_square_root_top.f]
+incdir+hw/rtl
hw/rtl/isqrt_pkg.sv
hw/rtl/isqrt_cell.sv
hw/rtl/integer_square_root_top.sv
tb/tb_top.sv
